// ===== rtl/core/twsp_pkg.sv =====
// Types, codes and helpers shared by the tagged wire stream parser modules.
`timescale 1ns / 1ps
package twsp_pkg;

	// event codes carried on event_kind
	localparam logic [3:0] EV_INT    = 4'd0;
	localparam logic [3:0] EV_B8     = 4'd1;
	localparam logic [3:0] EV_B32    = 4'd2;
	localparam logic [3:0] EV_B64    = 4'd3;
	localparam logic [3:0] EV_FLOAT  = 4'd4;
	localparam logic [3:0] EV_ENUM   = 4'd5;
	localparam logic [3:0] EV_TUPLE  = 4'd6;
	localparam logic [3:0] EV_HTUPLE = 4'd7;
	localparam logic [3:0] EV_BYTES  = 4'd8;
	localparam logic [3:0] EV_BYTE   = 4'd9;
	localparam logic [3:0] EV_ASSOC  = 4'd10;
	localparam logic [3:0] EV_CLOSE  = 4'd11;
	localparam logic [3:0] EV_END    = 4'd12;
	localparam logic [3:0] EV_ERROR  = 4'd13;

	// error codes
	localparam logic [3:0] ERR_NOT_TUPLE = 4'd1;
	localparam logic [3:0] ERR_BAD_TYPE  = 4'd2;
	localparam logic [3:0] ERR_LENGTH    = 4'd3;
	localparam logic [3:0] ERR_VARINT    = 4'd4;
	localparam logic [3:0] ERR_DEPTH     = 4'd5;

	// wire types from the element prefix
	localparam logic [3:0] WT_VINT   = 4'd0;
	localparam logic [3:0] WT_TUPLE  = 4'd1;
	localparam logic [3:0] WT_B8     = 4'd2;
	localparam logic [3:0] WT_BYTES  = 4'd3;
	localparam logic [3:0] WT_B32    = 4'd4;
	localparam logic [3:0] WT_HTUPLE = 4'd5;
	localparam logic [3:0] WT_B64    = 4'd6;
	localparam logic [3:0] WT_ASSOC  = 4'd7;
	localparam logic [3:0] WT_FLOAT  = 4'd8;
	localparam logic [3:0] WT_ENUM   = 4'd10;

	// kinds of an open level
	localparam logic [1:0] LK_MESSAGE = 2'd0;
	localparam logic [1:0] LK_TUPLE   = 2'd1;
	localparam logic [1:0] LK_HTUPLE  = 2'd2;
	localparam logic [1:0] LK_ASSOC   = 2'd3;

	// most results reported for one input word
	localparam logic [3:0] MAX_RESULTS = 4'd10;
	// result queue depth
	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [3:0]  kind;
		logic [27:0] tag;
		logic [63:0] value;
		logic [3:0]  level;
		logic        last;
	} event_t;

	// opening event code for a level kind
	function automatic logic [3:0] open_code(input logic [1:0] lk);
		logic [3:0] code;
		code = EV_TUPLE;
		if (lk == LK_HTUPLE) code = EV_HTUPLE;
		else if (lk == LK_ASSOC) code = EV_ASSOC;
		return code;
	endfunction

endpackage

// ===== rtl/core/twsp_front.sv =====
// Front end: takes stream words, decodes varints and scalars, keeps the level stack, emits events.
`timescale 1ns / 1ps
module twsp_front #(
	parameter int NESTING_DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              restart,
	input  logic              full,
	output logic              push,
	output twsp_pkg::event_t  push_ev
);

	localparam int SPW = $clog2(NESTING_DEPTH + 1);
	localparam int IW  = $clog2(NESTING_DEPTH);

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_MSG_LEN = 9'b000000010,
		PH_COUNT   = 9'b000000100,
		PH_PREFIX  = 9'b000001000,
		PH_VINT    = 9'b000010000,
		PH_SCALAR  = 9'b000100000,
		PH_CLEN    = 9'b001000000,
		PH_BYTES   = 9'b010000000,
		PH_TRAIL   = 9'b100000000
	} phase_t;

	typedef enum logic [2:0] {
		M_RUN    = 3'b001,
		M_SETTLE = 3'b010,
		M_ERR    = 3'b100
	} mode_t;

	phase_t            phase_q, phase_d, eff_ph;
	mode_t             mode_q, mode_d;
	logic [31:0]       acc_q, acc_d, eff_acc;
	logic [5:0]        sh_q, sh_d, eff_sh;
	logic [27:0]       tag_q, tag_d;
	logic [3:0]        wt_q, wt_d;
	logic [63:0]       sreg_q, sreg_d;
	logic [3:0]        sbl_q, sbl_d;
	logic [31:0]       str_q, str_d;
	logic [SPW-1:0]    sp_q, sp_d, eff_sp, errlvl_q, errlvl_d;
	logic [3:0]        cnt_q, cnt_d;

	logic [31:0]       elem_q  [NESTING_DEPTH];
	logic [31:0]       bytes_q [NESTING_DEPTH];
	logic [1:0]        kind_q  [NESTING_DEPTH];

	logic              ew_en, bw_en, kw_en, dec_all;
	logic [IW-1:0]     ew_idx, bw_idx, kw_idx;
	logic [31:0]       ew_val, bw_val;
	logic [1:0]        kw_val;

	logic [31:0]       vacc;
	logic              vtoo, vcont, ph_ge;
	logic [SPW-1:0]    spm1, sspm1, sspm2;
	logic [IW-1:0]     idx_top, idx_sp, idx_s1, idx_s2;
	logic [31:0]       e_top, b_top;
	logic [1:0]        k_top;
	logic              ev_vld;
	twsp_pkg::event_t  ev;

	// apply restart ahead of the word
	always_comb begin
		eff_ph  = restart ? PH_IDLE : phase_q;
		eff_acc = restart ? '0 : acc_q;
		eff_sh  = restart ? '0 : sh_q;
		eff_sp  = restart ? '0 : sp_q;
	end

	// varint step and stack reads
	assign vacc    = eff_acc | (32'(data_byte[6:0]) << eff_sh);
	assign vtoo    = (eff_sh >= 6'd28) && (data_byte[7:4] != 4'd0);
	assign vcont   = data_byte[7];
	assign ph_ge   = (eff_ph == PH_COUNT) || (eff_ph == PH_PREFIX) || (eff_ph == PH_VINT) ||
		(eff_ph == PH_SCALAR) || (eff_ph == PH_CLEN) || (eff_ph == PH_BYTES);
	assign spm1    = eff_sp - SPW'(1);
	assign idx_top = spm1[IW-1:0];
	assign idx_sp  = eff_sp[IW-1:0];
	assign sspm1   = sp_q - SPW'(1);
	assign sspm2   = sp_q - SPW'(2);
	assign idx_s1  = sspm1[IW-1:0];
	assign idx_s2  = sspm2[IW-1:0];
	assign e_top   = elem_q[idx_top];
	assign b_top   = bytes_q[idx_top];
	assign k_top   = kind_q[idx_top];

	assign in_ready = (mode_q == M_RUN) && !full;

	// decode one word, or step a close cascade, or report a held error
	always_comb begin
		logic              prim, err, want_settle, do_fail, opened, vdone, in_rng, is_vph;
		logic [3:0]        fcode, total, sbl_eff, pos;
		logic [31:0]       el_after, chk_b, sv, ebuf;
		logic [63:0]       sreg_new;
		logic [SPW-1:0]    lvl;
		twsp_pkg::event_t  pe;

		phase_d = phase_q; acc_d = acc_q; sh_d = sh_q; tag_d = tag_q; wt_d = wt_q;
		sreg_d = sreg_q; sbl_d = sbl_q; str_d = str_q; sp_d = sp_q;
		mode_d = mode_q; errlvl_d = errlvl_q; cnt_d = cnt_q;
		ew_en = 1'b0; ew_idx = idx_top; ew_val = '0;
		bw_en = 1'b0; bw_idx = idx_top; bw_val = '0;
		kw_en = 1'b0; kw_idx = idx_top; kw_val = twsp_pkg::LK_MESSAGE;
		dec_all = 1'b0; ev_vld = 1'b0; ev = '0;
		prim = 1'b0; err = 1'b0; want_settle = 1'b0; do_fail = 1'b0; opened = 1'b0;
		vdone = 1'b0; in_rng = 1'b0; is_vph = 1'b0;
		fcode = twsp_pkg::ERR_LENGTH; total = 4'd8; sbl_eff = 4'd0; pos = 4'd0;
		el_after = '0; chk_b = b_top; sv = '0; ebuf = '0; sreg_new = sreg_q;
		lvl = eff_sp; pe = '0;

		unique case (mode_q)
			M_RUN: begin
				if (in_valid && !full) begin
					phase_d = eff_ph; acc_d = eff_acc; sh_d = eff_sh; sp_d = eff_sp;
					if (eff_ph == PH_TRAIL) begin
						// consume trailing budget silently
						bw_en  = 1'b1;
						bw_idx = '0;
						bw_val = (bytes_q[0] != 32'd0) ? bytes_q[0] - 32'd1 : 32'd0;
						if (bw_val == 32'd0) phase_d = PH_IDLE;
					end else if (ph_ge && (eff_sp == '0 || b_top == 32'd0)) begin
						do_fail = 1'b1;
						fcode   = twsp_pkg::ERR_LENGTH;
					end else begin
						dec_all = ph_ge;
						chk_b   = ph_ge ? b_top - 32'd1 : b_top;
						is_vph  = (eff_ph == PH_IDLE) || (eff_ph == PH_MSG_LEN) ||
							(eff_ph == PH_COUNT) || (eff_ph == PH_PREFIX) ||
							(eff_ph == PH_VINT) || (eff_ph == PH_CLEN);
						// shared varint front
						if (is_vph) begin
							if (vtoo) begin
								do_fail = 1'b1;
								fcode   = twsp_pkg::ERR_VARINT;
							end else if (vcont) begin
								acc_d = vacc;
								sh_d  = eff_sh + 6'd7;
							end else begin
								acc_d = '0;
								sh_d  = '0;
								vdone = 1'b1;
							end
						end
						unique case (eff_ph)
							PH_IDLE: begin
								if (vdone) begin
									if (vacc[3:0] != twsp_pkg::WT_TUPLE) begin
										do_fail = 1'b1;
										fcode   = twsp_pkg::ERR_NOT_TUPLE;
									end else begin
										tag_d   = vacc[31:4];
										wt_d    = twsp_pkg::WT_TUPLE;
										phase_d = PH_MSG_LEN;
									end
								end
							end
							PH_MSG_LEN: begin
								if (vdone) begin
									kw_en = 1'b1; kw_idx = '0; kw_val = twsp_pkg::LK_MESSAGE;
									bw_en = 1'b1; bw_idx = '0; bw_val = vacc;
									ew_en = 1'b1; ew_idx = '0; ew_val = '0;
									sp_d    = SPW'(1);
									phase_d = PH_COUNT;
									opened  = 1'b1;
									chk_b   = vacc;
								end
							end
							PH_COUNT: begin
								if (vdone) begin
									if (k_top == twsp_pkg::LK_ASSOC)
										el_after = vacc[31] ? 32'hFFFF_FFFF : {vacc[30:0], 1'b0};
									else
										el_after = vacc;
									ew_en = 1'b1; ew_idx = idx_top; ew_val = el_after;
									prim  = 1'b1;
									pe.kind  = twsp_pkg::open_code(k_top);
									pe.tag   = tag_q;
									pe.value = {32'd0, vacc};
									pe.level = 4'(spm1);
									want_settle = 1'b1;
								end
							end
							PH_PREFIX: begin
								if (vdone) begin
									tag_d  = vacc[31:4];
									wt_d   = vacc[3:0];
									sreg_d = '0;
									case (vacc[3:0])
										twsp_pkg::WT_VINT: phase_d = PH_VINT;
										twsp_pkg::WT_B8: begin
											sbl_d = 4'd1; phase_d = PH_SCALAR;
										end
										twsp_pkg::WT_B32: begin
											sbl_d = 4'd4; phase_d = PH_SCALAR;
										end
										twsp_pkg::WT_B64, twsp_pkg::WT_FLOAT: begin
											sbl_d = 4'd8; phase_d = PH_SCALAR;
										end
										twsp_pkg::WT_ENUM: begin
											prim = 1'b1;
											pe.kind  = twsp_pkg::EV_ENUM;
											pe.tag   = vacc[31:4];
											pe.level = 4'(eff_sp);
											want_settle = 1'b1;
										end
										twsp_pkg::WT_TUPLE, twsp_pkg::WT_BYTES,
										twsp_pkg::WT_HTUPLE, twsp_pkg::WT_ASSOC:
											phase_d = PH_CLEN;
										default: begin
											do_fail = 1'b1;
											fcode   = twsp_pkg::ERR_BAD_TYPE;
										end
									endcase
								end
							end
							PH_VINT: begin
								if (vdone) begin
									sv   = (vacc >> 1) ^ {32{vacc[0]}};
									prim = 1'b1;
									pe.kind  = twsp_pkg::EV_INT;
									pe.tag   = tag_q;
									pe.value = {{32{sv[31]}}, sv};
									pe.level = 4'(eff_sp);
									want_settle = 1'b1;
								end
							end
							PH_SCALAR: begin
								total = (wt_q == twsp_pkg::WT_B8) ? 4'd1 :
									((wt_q == twsp_pkg::WT_B32) ? 4'd4 : 4'd8);
								sbl_eff  = (sbl_q == 4'd0 || sbl_q > total) ? total : sbl_q;
								pos      = total - sbl_eff;
								sreg_new = sreg_q | (64'(data_byte) << {pos[2:0], 3'b000});
								sreg_d   = sreg_new;
								sbl_d    = sbl_eff - 4'd1;
								if (sbl_eff == 4'd1) begin
									prim = 1'b1;
									pe.tag   = tag_q;
									pe.level = 4'(eff_sp);
									if (wt_q == twsp_pkg::WT_B8) begin
										pe.kind  = twsp_pkg::EV_B8;
										pe.value = sreg_new;
									end else if (wt_q == twsp_pkg::WT_B32) begin
										pe.kind  = twsp_pkg::EV_B32;
										pe.value = {{32{sreg_new[31]}}, sreg_new[31:0]};
									end else begin
										pe.kind  = (wt_q == twsp_pkg::WT_B64) ?
											twsp_pkg::EV_B64 : twsp_pkg::EV_FLOAT;
										pe.value = sreg_new;
									end
									want_settle = 1'b1;
								end
							end
							PH_CLEN: begin
								if (vdone) begin
									if (vacc > chk_b) begin
										do_fail = 1'b1;
										fcode   = twsp_pkg::ERR_LENGTH;
									end else if (wt_q == twsp_pkg::WT_BYTES) begin
										prim = 1'b1;
										pe.kind  = twsp_pkg::EV_BYTES;
										pe.tag   = tag_q;
										pe.value = {32'd0, vacc};
										pe.level = 4'(eff_sp);
										if (vacc == 32'd0) begin
											want_settle = 1'b1;
										end else begin
											str_d   = vacc;
											phase_d = PH_BYTES;
										end
									end else if (eff_sp >= SPW'(NESTING_DEPTH)) begin
										do_fail = 1'b1;
										fcode   = twsp_pkg::ERR_DEPTH;
									end else begin
										kw_en  = 1'b1;
										kw_idx = idx_sp;
										kw_val = (wt_q == twsp_pkg::WT_TUPLE) ? twsp_pkg::LK_TUPLE :
											((wt_q == twsp_pkg::WT_HTUPLE) ? twsp_pkg::LK_HTUPLE :
											twsp_pkg::LK_ASSOC);
										bw_en = 1'b1; bw_idx = idx_sp; bw_val = vacc;
										ew_en = 1'b1; ew_idx = idx_sp; ew_val = '0;
										sp_d    = eff_sp + SPW'(1);
										phase_d = PH_COUNT;
										opened  = 1'b1;
										chk_b   = vacc;
									end
								end
							end
							PH_BYTES: begin
								prim = 1'b1;
								pe.kind  = twsp_pkg::EV_BYTE;
								pe.tag   = tag_q;
								pe.value = {56'd0, data_byte};
								pe.level = 4'(eff_sp);
								str_d = (str_q != 32'd0) ? str_q - 32'd1 : 32'd0;
								if (str_d == 32'd0) want_settle = 1'b1;
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
						// element finished: count it off, except an open already set it
						if (want_settle && eff_ph != PH_COUNT) begin
							el_after = (e_top != 32'd0) ? e_top - 32'd1 : 32'd0;
							ew_en = 1'b1; ew_idx = idx_top; ew_val = el_after;
						end
					end

					// cascade or settle straight away
					if (!do_fail && want_settle) begin
						if (el_after == 32'd0) mode_d = M_SETTLE;
						else phase_d = PH_PREFIX;
					end
					in_rng = (phase_d == PH_COUNT) || (phase_d == PH_PREFIX) ||
						(phase_d == PH_VINT) || (phase_d == PH_SCALAR) ||
						(phase_d == PH_CLEN) || (phase_d == PH_BYTES);
					if (!opened && eff_ph != PH_COUNT && !ph_ge) chk_b = b_top;
					err = do_fail || (!do_fail && mode_d != M_SETTLE && in_rng &&
						(sp_d == '0 || chk_b == 32'd0));
					lvl = do_fail ? eff_sp : sp_d;
					if (err) begin
						phase_d = PH_IDLE; acc_d = '0; sh_d = '0; sp_d = '0;
					end
					cnt_d = '0;
					if (prim) begin
						ev_vld  = 1'b1;
						ev      = pe;
						ev.last = (mode_d != M_SETTLE) && !err;
						if (err) begin
							mode_d   = M_ERR;
							errlvl_d = lvl;
						end
						cnt_d = 4'd1;
					end else if (err) begin
						ev_vld   = 1'b1;
						ev.kind  = twsp_pkg::EV_ERROR;
						ev.value = {60'd0, fcode};
						ev.level = 4'(lvl);
						ev.last  = 1'b1;
						cnt_d    = 4'd1;
					end
				end
			end
			M_SETTLE: begin
				if (!full) begin
					ev_vld = 1'b1;
					if (sspm1 == '0) begin
						// message finished
						ev.kind = twsp_pkg::EV_END;
						ev.last = 1'b1;
						phase_d = (bytes_q[0] != 32'd0) ? PH_TRAIL : PH_IDLE;
						sp_d    = '0;
						mode_d  = M_RUN;
					end else begin
						ev.kind  = twsp_pkg::EV_CLOSE;
						ev.value = {60'd0, twsp_pkg::open_code(kind_q[idx_s1])};
						ev.level = 4'(sspm1);
						ebuf     = elem_q[idx_s2];
						el_after = (ebuf != 32'd0) ? ebuf - 32'd1 : 32'd0;
						ew_en = 1'b1; ew_idx = idx_s2; ew_val = el_after;
						sp_d  = sspm1;
						if (el_after != 32'd0) begin
							phase_d = PH_PREFIX;
							if (bytes_q[idx_s2] == 32'd0) begin
								phase_d = PH_IDLE; acc_d = '0; sh_d = '0; sp_d = '0;
								mode_d   = M_ERR;
								errlvl_d = sspm1;
							end else begin
								ev.last = 1'b1;
								mode_d  = M_RUN;
							end
						end
					end
				end
			end
			M_ERR: begin
				if (!full) begin
					// report the budget error held back behind an event
					ev_vld   = 1'b1;
					ev.kind  = twsp_pkg::EV_ERROR;
					ev.value = {60'd0, twsp_pkg::ERR_LENGTH};
					ev.level = 4'(errlvl_q);
					ev.last  = 1'b1;
					mode_d   = M_RUN;
				end
			end
			default: begin
				mode_d = M_RUN;
			end
		endcase

		// drop results past the per-word limit
		if (mode_q != M_RUN && ev_vld) begin
			if (cnt_q >= twsp_pkg::MAX_RESULTS) begin
				ev_vld = 1'b0;
			end else begin
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == twsp_pkg::MAX_RESULTS - 4'd1) ev.last = 1'b1;
			end
		end
	end

	assign push    = ev_vld;
	assign push_ev = ev;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			mode_q   <= M_RUN;
			acc_q    <= '0;
			sh_q     <= '0;
			tag_q    <= '0;
			wt_q     <= '0;
			sreg_q   <= '0;
			sbl_q    <= '0;
			str_q    <= '0;
			sp_q     <= '0;
			errlvl_q <= '0;
			cnt_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			mode_q   <= mode_d;
			acc_q    <= acc_d;
			sh_q     <= sh_d;
			tag_q    <= tag_d;
			wt_q     <= wt_d;
			sreg_q   <= sreg_d;
			sbl_q    <= sbl_d;
			str_q    <= str_d;
			sp_q     <= sp_d;
			errlvl_q <= errlvl_d;
			cnt_q    <= cnt_d;
		end
	end

	// level stack: one write per store, budgets of open levels count down together
	always_ff @(posedge clk) begin
		for (int i = 0; i < NESTING_DEPTH; i++) begin
			if (ew_en && ew_idx == IW'(i)) elem_q[i] <= ew_val;
			if (kw_en && kw_idx == IW'(i)) kind_q[i] <= kw_val;
			if (bw_en && bw_idx == IW'(i))
				bytes_q[i] <= bw_val;
			else if (dec_all && SPW'(i) < sp_q && bytes_q[i] != 32'd0)
				bytes_q[i] <= bytes_q[i] - 32'd1;
		end
	end

endmodule

// ===== rtl/core/twsp_queue.sv =====
// Back end: short result queue that carries events to the output port.
`timescale 1ns / 1ps
module twsp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  twsp_pkg::event_t  push_ev,
	output logic              full,
	output logic              out_valid,
	input  logic              out_ready,
	output twsp_pkg::event_t  head
);

	localparam int PW = $clog2(twsp_pkg::QDEPTH);

	twsp_pkg::event_t  mem_q [twsp_pkg::QDEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [PW:0]       cnt_q;
	logic              pop;

	assign full      = (cnt_q == (PW+1)'(twsp_pkg::QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop) rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	// hold event words
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_ev;
	end

endmodule

// ===== rtl/core/tagged_wire_stream_parser.sv =====
// Top level of the tagged wire stream parser: front decoder and result queue.
//
//  channel | handshake          | word
//  --------+--------------------+-----------------------------------------------
//  input   | in_valid/in_ready  | data_byte, restart
//  output  | out_valid/out_ready| event_kind, field_tag, field_value,
//          |                    | nesting_level, last_of_run
//
// One stream word is taken per cycle when the word yields at most one event.
// Each close or end of a cascade takes a step of its own in the front end, as does
// a length error reported behind an event; input is held during those steps.
// A four-word result queue parts front and back, so out_ready low stalls input
// only once the queue is full. Reset empties the queue and idles the parser.
`timescale 1ns / 1ps
module tagged_wire_stream_parser #(
	parameter int NESTING_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         event_kind,
	output logic [27:0]        field_tag,
	output logic signed [63:0] field_value,
	output logic [3:0]         nesting_level,
	output logic               last_of_run
);

	logic              full, push;
	twsp_pkg::event_t  push_ev, head;

	twsp_front #(
		.NESTING_DEPTH(NESTING_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.restart   (restart),
		.full      (full),
		.push      (push),
		.push_ev   (push_ev)
	);

	twsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ev   (push_ev),
		.full      (full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	// drive result word from queue head
	assign event_kind    = head.kind;
	assign field_tag     = head.tag;
	assign field_value   = $signed(head.value);
	assign nesting_level = head.level;
	assign last_of_run   = head.last;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the tagged wire stream parser.
`timescale 1ns / 1ps
module testbench;

	localparam int DEPTH = 8;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	// parser phases of the predictor
	typedef enum int {P_IDLE, P_MSG_LEN, P_COUNT, P_PREFIX, P_VINT, P_SCALAR,
		P_CLEN, P_BYTES, P_TRAIL} phase_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] event_kind;
	logic [27:0] field_tag;
	logic signed [63:0] field_value;
	logic [3:0] nesting_level;
	logic last_of_run;

	tagged_wire_stream_parser #(.NESTING_DEPTH(DEPTH)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .restart(restart), .out_valid(out_valid),
		.out_ready(out_ready), .event_kind(event_kind), .field_tag(field_tag),
		.field_value(field_value), .nesting_level(nesting_level),
		.last_of_run(last_of_run));

	always #4 clk = ~clk;

	// decoder state mirror
	phase_e phase;
	logic [31:0] acc;
	int unsigned shamt;
	logic [27:0] cur_tag;
	logic [3:0] cur_wt;
	logic [63:0] scal;
	int unsigned scal_left;
	logic [31:0] str_left;
	logic [31:0] elems_left[DEPTH];
	logic [31:0] budget_left[DEPTH];
	logic [1:0] lvl_kind[DEPTH];
	int unsigned sp;

	twsp_pkg::event_t expected_events[$];
	twsp_pkg::event_t step_events[$];
	int errors = 0;
	int bytes_sent = 0;
	int events_seen = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int hold_cnt = 0;
	bit hold_req = 1'b0;
	bit stall_mode = 1'b0;

	function automatic logic [63:0] sext32(input logic [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

	function automatic logic [3:0] kind_to_open(input logic [1:0] lk);
		return lk == twsp_pkg::LK_HTUPLE ? twsp_pkg::EV_HTUPLE :
			(lk == twsp_pkg::LK_ASSOC ? twsp_pkg::EV_ASSOC : twsp_pkg::EV_TUPLE);
	endfunction

	function automatic void push_event(input logic [3:0] k, input logic [27:0] t,
			input logic [63:0] v, input int unsigned l);
		twsp_pkg::event_t e;
		if (step_events.size() >= int'(twsp_pkg::MAX_RESULTS)) return;
		e.kind = k; e.tag = t; e.value = v; e.level = l[3:0]; e.last = 1'b0;
		step_events.push_back(e);
	endfunction

	function automatic void clear_state();
		phase = P_IDLE; acc = '0; shamt = 0; cur_tag = '0; cur_wt = '0;
		scal = '0; scal_left = 0; str_left = '0; sp = 0;
	endfunction

	function automatic void raise_error(input logic [3:0] code);
		push_event(twsp_pkg::EV_ERROR, '0, {60'd0, code}, sp);
		clear_state();
	endfunction

	// 1 done, 0 more, -1 too long
	function automatic int take_varint(input logic [7:0] b, output logic [31:0] val);
		val = '0;
		if (shamt >= 28 && b >= 16) begin
			acc = '0; shamt = 0;
			return -1;
		end
		acc = acc | (32'(b[6:0]) << shamt);
		if (b[7]) begin
			shamt += 7;
			return 0;
		end
		val = acc; acc = '0; shamt = 0;
		return 1;
	endfunction

	// pop finished levels, emitting closes and the end of message
	function automatic void unwind();
		while (sp > 0 && elems_left[sp-1] == 0) begin
			sp--;
			if (sp == 0) begin
				push_event(twsp_pkg::EV_END, '0, '0, 0);
				phase = budget_left[0] != 0 ? P_TRAIL : P_IDLE;
				return;
			end
			push_event(twsp_pkg::EV_CLOSE, '0, {60'd0, kind_to_open(lvl_kind[sp])}, sp);
			if (elems_left[sp-1] != 0) elems_left[sp-1]--;
		end
		phase = P_PREFIX;
	endfunction

	function automatic void finish_element();
		if (sp > 0 && elems_left[sp-1] != 0) elems_left[sp-1]--;
		unwind();
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic rs);
		logic [31:0] v;
		logic [32:0] twice;
		int r;
		int unsigned total;
		step_events.delete();
		if (rs) clear_state();
		if (phase == P_TRAIL) begin
			if (budget_left[0] != 0) budget_left[0]--;
			if (budget_left[0] == 0) phase = P_IDLE;
			return;
		end
		if (phase >= P_COUNT) begin
			if (sp == 0 || budget_left[sp-1] == 0) begin
				raise_error(twsp_pkg::ERR_LENGTH);
				flush_step();
				return;
			end
			for (int i = 0; i < sp; i++)
				if (budget_left[i] != 0) budget_left[i]--;
		end
		case (phase)
			P_IDLE: begin
				r = take_varint(b, v);
				if (r < 0) raise_error(twsp_pkg::ERR_VARINT);
				else if (r > 0) begin
					if (v[3:0] != twsp_pkg::WT_TUPLE) raise_error(twsp_pkg::ERR_NOT_TUPLE);
					else begin
						cur_tag = v[31:4]; cur_wt = twsp_pkg::WT_TUPLE; phase = P_MSG_LEN;
					end
				end
			end
			P_MSG_LEN: begin
				r = take_varint(b, v);
				if (r < 0) raise_error(twsp_pkg::ERR_VARINT);
				else if (r > 0) begin
					lvl_kind[0] = twsp_pkg::LK_MESSAGE; budget_left[0] = v;
					elems_left[0] = '0;
					sp = 1; phase = P_COUNT;
				end
			end
			P_COUNT: begin
				r = take_varint(b, v);
				if (r < 0) raise_error(twsp_pkg::ERR_VARINT);
				else if (r > 0) begin
					twice = {v, 1'b0};
					if (lvl_kind[sp-1] == twsp_pkg::LK_ASSOC)
						elems_left[sp-1] = twice[32] ? 32'hFFFF_FFFF : twice[31:0];
					else elems_left[sp-1] = v;
					push_event(kind_to_open(lvl_kind[sp-1]), cur_tag, {32'd0, v}, sp - 1);
					unwind();
				end
			end
			P_PREFIX: begin
				r = take_varint(b, v);
				if (r < 0) raise_error(twsp_pkg::ERR_VARINT);
				else if (r > 0) begin
					cur_tag = v[31:4]; cur_wt = v[3:0]; scal = '0;
					case (cur_wt)
						twsp_pkg::WT_VINT: phase = P_VINT;
						twsp_pkg::WT_B8: begin scal_left = 1; phase = P_SCALAR; end
						twsp_pkg::WT_B32: begin scal_left = 4; phase = P_SCALAR; end
						twsp_pkg::WT_B64, twsp_pkg::WT_FLOAT: begin
							scal_left = 8; phase = P_SCALAR;
						end
						twsp_pkg::WT_ENUM: begin
							push_event(twsp_pkg::EV_ENUM, cur_tag, '0, sp);
							finish_element();
						end
						twsp_pkg::WT_TUPLE, twsp_pkg::WT_BYTES, twsp_pkg::WT_HTUPLE,
						twsp_pkg::WT_ASSOC: phase = P_CLEN;
						default: raise_error(twsp_pkg::ERR_BAD_TYPE);
					endcase
				end
			end
			P_VINT: begin
				r = take_varint(b, v);
				if (r < 0) raise_error(twsp_pkg::ERR_VARINT);
				else if (r > 0) begin
					push_event(twsp_pkg::EV_INT, cur_tag,
						sext32((v >> 1) ^ (32'd0 - {31'd0, v[0]})), sp);
					finish_element();
				end
			end
			P_SCALAR: begin
				total = cur_wt == twsp_pkg::WT_B8 ? 1 : (cur_wt == twsp_pkg::WT_B32 ? 4 : 8);
				if (scal_left == 0 || scal_left > total) scal_left = total;
				scal = scal | (64'(b) << (8 * (total - scal_left)));
				scal_left--;
				if (scal_left == 0) begin
					if (cur_wt == twsp_pkg::WT_B8)
						push_event(twsp_pkg::EV_B8, cur_tag, scal, sp);
					else if (cur_wt == twsp_pkg::WT_B32)
						push_event(twsp_pkg::EV_B32, cur_tag, sext32(scal[31:0]), sp);
					else
						push_event(cur_wt == twsp_pkg::WT_B64 ? twsp_pkg::EV_B64 :
							twsp_pkg::EV_FLOAT, cur_tag, scal, sp);
					finish_element();
				end
			end
			P_CLEN: begin
				r = take_varint(b, v);
				if (r < 0) raise_error(twsp_pkg::ERR_VARINT);
				else if (r > 0) begin
					if (v > budget_left[sp-1]) raise_error(twsp_pkg::ERR_LENGTH);
					else if (cur_wt == twsp_pkg::WT_BYTES) begin
						push_event(twsp_pkg::EV_BYTES, cur_tag, {32'd0, v}, sp);
						if (v == 0) finish_element();
						else begin
							str_left = v; phase = P_BYTES;
						end
					end else if (sp >= DEPTH) raise_error(twsp_pkg::ERR_DEPTH);
					else begin
						lvl_kind[sp] = cur_wt == twsp_pkg::WT_TUPLE ? twsp_pkg::LK_TUPLE :
							(cur_wt == twsp_pkg::WT_HTUPLE ? twsp_pkg::LK_HTUPLE :
							twsp_pkg::LK_ASSOC);
						budget_left[sp] = v; elems_left[sp] = '0;
						sp++; phase = P_COUNT;
					end
				end
			end
			P_BYTES: begin
				push_event(twsp_pkg::EV_BYTE, cur_tag, {56'd0, b}, sp);
				if (str_left != 0) str_left--;
				if (str_left == 0) finish_element();
			end
			default: clear_state();
		endcase
		if (phase >= P_COUNT && phase <= P_BYTES && (sp == 0 || budget_left[sp-1] == 0))
			raise_error(twsp_pkg::ERR_LENGTH);
		flush_step();
	endfunction

	// mark the final event of the byte and queue the lot
	function automatic void flush_step();
		if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
		foreach (step_events[i]) expected_events.push_back(step_events[i]);
		step_events.delete();
	endfunction

	// send one word and predict its events at acceptance
	task automatic send_byte(input logic [7:0] b, input logic rs = 1'b0);
		int gap;
		gap = 0;
		data_byte <= b;
		restart <= rs;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		decode_byte(b, rs);
		bytes_sent++;
		// close a burst with an idle gap
		if (stall_mode) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
			end else burst_left--;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_varint(input logic [31:0] v);
		do begin
			send_byte({v > 127 ? 1'b1 : 1'b0, v[6:0]});
			v = v >> 7;
		end while (v != 0);
	endtask

	// stop offering and wait for every predicted event
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// element body builder: bytes of one random scalar element
	function automatic void build_scalar(ref logic [7:0] buf_q[$], input logic [27:0] tag);
		logic [3:0] wt;
		logic [31:0] v;
		int n;
		case ($urandom_range(0, 6))
			0: wt = twsp_pkg::WT_VINT;
			1: wt = twsp_pkg::WT_B8;
			2: wt = twsp_pkg::WT_B32;
			3: wt = twsp_pkg::WT_B64;
			4: wt = twsp_pkg::WT_FLOAT;
			5: wt = twsp_pkg::WT_ENUM;
			default: wt = twsp_pkg::WT_BYTES;
		endcase
		put_varint(buf_q, {tag, wt});
		case (wt)
			twsp_pkg::WT_VINT: begin
				v = $urandom();
				if ($urandom_range(0, 1)) v = v >> $urandom_range(0, 31);
				put_varint(buf_q, v);
			end
			twsp_pkg::WT_B8: buf_q.push_back(8'($urandom()));
			twsp_pkg::WT_B32: repeat (4) buf_q.push_back(8'($urandom()));
			twsp_pkg::WT_B64, twsp_pkg::WT_FLOAT: repeat (8) buf_q.push_back(8'($urandom()));
			twsp_pkg::WT_BYTES: begin
				n = $urandom_range(0, 4);
				put_varint(buf_q, 32'(n));
				repeat (n) buf_q.push_back(8'($urandom()));
			end
			default: ;
		endcase
	endfunction

	function automatic void put_varint(ref logic [7:0] buf_q[$], input logic [31:0] v);
		do begin
			buf_q.push_back({v > 127 ? 1'b1 : 1'b0, v[6:0]});
			v = v >> 7;
		end while (v != 0);
	endfunction

	// container body: count then elements; returns the encoded bytes
	function automatic void build_body(ref logic [7:0] buf_q[$], input int lvl,
			input bit is_assoc);
		int cnt;
		int elems;
		logic [7:0] inner[$];
		logic [3:0] wt;
		cnt = $urandom_range(0, 3);
		elems = is_assoc ? 2 * cnt : cnt;
		put_varint(buf_q, 32'(cnt));
		repeat (elems) begin
			if (lvl < DEPTH + 1 && $urandom_range(0, 3) == 0) begin
				inner.delete();
				case ($urandom_range(0, 2))
					0: wt = twsp_pkg::WT_TUPLE;
					1: wt = twsp_pkg::WT_HTUPLE;
					default: wt = twsp_pkg::WT_ASSOC;
				endcase
				build_body(inner, lvl + 1, wt == twsp_pkg::WT_ASSOC);
				put_varint(buf_q, {28'($urandom()), wt});
				put_varint(buf_q, 32'(inner.size()));
				foreach (inner[i]) buf_q.push_back(inner[i]);
			end else build_scalar(buf_q, 28'($urandom()));
		end
	endfunction

	// whole message with a random amount of trailing slack
	task automatic send_random_message();
		logic [7:0] body[$];
		logic [7:0] msg[$];
		int slack;
		build_body(body, 1, 1'b0);
		slack = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
		repeat (slack) body.push_back(8'($urandom()));
		put_varint(msg, {28'($urandom()), twsp_pkg::WT_TUPLE});
		put_varint(msg, 32'(body.size()));
		foreach (body[i]) msg.push_back(body[i]);
		// break some messages: corrupt a byte
		if ($urandom_range(0, 9) == 0) msg[$urandom_range(0, msg.size()-1)] = 8'($urandom());
		foreach (msg[i]) send_byte(msg[i], i == 0 && $urandom_range(0, 1) == 1);
	endtask

	// extremes, element types, special cases
	task automatic test_directed();
		// element types but the nested plain tuple in one message at tag extremes
		send_byte(8'h01, 1'b1); send_byte(8'd40); send_byte(8'd9);
		send_varint({28'h0, twsp_pkg::WT_VINT}); send_byte(8'hFF); send_byte(8'hFF);
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h0F);
		send_varint({28'hFFF_FFFF, twsp_pkg::WT_B8}); send_byte(8'h80);
		send_varint({28'h1, twsp_pkg::WT_B32}); repeat (4) send_byte(8'hFF);
		send_varint({28'h2, twsp_pkg::WT_B64}); repeat (8) send_byte(8'h80);
		send_varint({28'h3, twsp_pkg::WT_ENUM});
		send_varint({28'h4, twsp_pkg::WT_BYTES}); send_byte(8'd0);
		send_varint({28'h5, twsp_pkg::WT_HTUPLE}); send_byte(8'd1); send_byte(8'd0);
		send_varint({28'h6, twsp_pkg::WT_ASSOC}); send_byte(8'd1); send_byte(8'd0);
		send_varint({28'h7, twsp_pkg::WT_FLOAT}); repeat (4) send_byte(8'h00);
	endtask

	task automatic test_errors();
		drain();
		send_byte(8'h00, 1'b1);                      // not a tuple
		send_byte(8'h01); send_byte(8'd0);           // empty message
		send_byte(8'h01); send_byte(8'd5); send_byte(8'd1); send_byte(8'h0C); // bad type
		repeat (4) send_byte(8'hFF); send_byte(8'h10); // varint too long
		send_byte(8'h01); send_byte(8'd3); send_byte(8'd1); send_byte(8'h01); send_byte(8'd9);
		// nest past the stack
		send_byte(8'h01); send_byte(8'd40); send_byte(8'd1);
		for (int i = 0; i < DEPTH; i++) begin
			send_byte(8'h01); send_byte(8'(30 - 3 * i)); send_byte(8'd1);
		end
		send_byte(8'hFF, 1'b1); send_byte(8'h7F); // restart mid-message, then resync
		drain();
	endtask

	// deep cascade of closes from one byte
	task automatic test_cascade();
		send_byte(8'h01, 1'b1); send_byte(8'd24); send_byte(8'd1);
		for (int i = 0; i < DEPTH - 1; i++) begin
			send_byte(8'h05); send_byte(8'(20 - 3 * i)); send_byte(8'd1);
		end
		send_byte(8'h02); send_byte(8'hA5);
		drain();
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (6) send_random_message();
		hold_req = 1'b0;
		drain();
	endtask

	task automatic test_random();
		stall_mode = 1'b1;
		while (bytes_sent < 420) begin
			if ($urandom_range(0, 15) == 0)
				send_byte(8'($urandom()), $urandom_range(0, 1) == 1);
			else send_random_message();
		end
		send_byte(8'h00, 1'b1);
		stall_mode = 1'b0;
	endtask

	// receiver: own stall pattern, one long counted hold on request
	always @(posedge clk) begin
		if (hold_req && hold_cnt < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_cnt  <= hold_cnt + 1;
		end else begin
			out_ready <= ($urandom_range(0, 7) < 5) || !stall_mode;
			if (!hold_req) hold_cnt <= 0;
		end
	end

	// compare each accepted event against the oldest prediction
	always @(posedge clk) begin
		twsp_pkg::event_t e;
		if (arst_n && out_valid && out_ready) begin
			events_seen++;
			if (expected_events.size() == 0) begin
				$error("unexpected event kind %0d", event_kind);
				errors++;
			end else begin
				e = expected_events.pop_front();
				if (event_kind !== e.kind) begin
					$error("event_kind: expected %0d, got %0d", e.kind, event_kind); errors++;
				end
				if (field_tag !== e.tag) begin
					$error("field_tag: expected %0h, got %0h", e.tag, field_tag); errors++;
				end
				if (field_value !== e.value) begin
					$error("field_value: expected %0h, got %0h", e.value, field_value); errors++;
				end
				if (nesting_level !== e.level) begin
					$error("nesting_level: expected %0d, got %0d", e.level, nesting_level);
					errors++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run: expected %0b, got %0b", e.last, last_of_run); errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT && (in_valid || expected_events.size() != 0)) begin
			$display("tagged_wire_stream_parser: mismatch");
			$finish;
		end
	end

	initial begin
		clear_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_errors();
		test_cascade();
		test_backpressure();
		test_random();
		drain();
		$display("Sent %0d stream bytes; checked %0d events across all element types,",
			bytes_sent, events_seen);
		$display("error paths, deep close cascades and output back-pressure.");
		if (errors == 0 && expected_events.size() == 0) begin
			$display("tagged_wire_stream_parser: match");
		end else begin
			$display("tagged_wire_stream_parser: mismatch");
		end
		$finish;
	end

endmodule
